[hdl/iss_pkg.sv]
// shared constants and types for the indexed sequence store
`default_nettype none
package iss_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int MODE_W     = 3;
	localparam int POS_W      = 5;
	localparam int ST_W       = 2;

	localparam logic [MODE_W-1:0] MODE_READ      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PUSH      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd5;
	localparam logic [MODE_W-1:0] MODE_POP_AT    = 3'd6;
	localparam logic [MODE_W-1:0] MODE_POP_LAST  = 3'd7;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
	} iss_cmd_t;

endpackage
`default_nettype wire

[hdl/iss_ctrl.sv]
// controller state machine: accept, execute, respond
`default_nettype none
module iss_ctrl
	import iss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output iss_cmd_t      cmd,
	output logic          busy,
	output logic          done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       take;

	assign busy = (state_q == S_EXEC);
	assign done = (state_q == S_RESP);
	assign take = start && !busy;

	assign cmd.load = take;
	assign cmd.exec = (state_q == S_EXEC);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				state_d = take ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[hdl/iss_dp.sv]
// datapath: shifting cell array, length register and result registers
`default_nettype none
module iss_dp
	import iss_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire iss_cmd_t                cmd,
	input  wire logic [MODE_W-1:0]       mode,
	input  wire logic [POS_W-1:0]        position,
	input  wire logic signed [31:0]      data_in,
	output logic signed [31:0]           data_out,
	output logic [CNT_W-1:0]             count,
	output logic [ST_W-1:0]              status
);

	logic [MODE_W-1:0]     mode_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;

	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
	logic [CNT_W-1:0]      cnt_q;
	logic [31:0]           res_q;
	logic [ST_W-1:0]       st_q;

	logic                  in_range;
	logic                  full;
	logic                  do_write;
	logic                  do_open;
	logic                  do_close;
	logic [CNT_W-1:0]      at;
	logic [ST_W-1:0]       st_d;
	logic                  give_res;
	logic [DATA_WIDTH-1:0] sel_val;

	// position is 5 bits, length register may be narrower or wider
	assign in_range = ({{CNT_W{1'b0}}, pos_q} < {{POS_W{1'b0}}, cnt_q});
	assign full     = (cnt_q == CNT_W'(CAPACITY));

	always_comb begin
		do_write = 1'b0;
		do_open  = 1'b0;
		do_close = 1'b0;
		give_res = 1'b0;
		st_d     = ST_OK;
		at       = CNT_W'(pos_q);
		case (mode_q)
			MODE_READ: begin
				if (in_range) give_res = 1'b1; else st_d = ST_RANGE;
			end
			MODE_WRITE: begin
				if (in_range) do_write = 1'b1; else st_d = ST_RANGE;
			end
			MODE_APPEND: begin
				at = cnt_q;
				if (full) st_d = ST_FULL; else do_open = 1'b1;
			end
			MODE_PUSH: begin
				at = '0;
				if (full) st_d = ST_FULL; else do_open = 1'b1;
			end
			MODE_INSERT: begin
				if ({{CNT_W{1'b0}}, pos_q} > {{POS_W{1'b0}}, cnt_q}) st_d = ST_RANGE;
				else if (full) st_d = ST_FULL;
				else do_open = 1'b1;
			end
			MODE_REMOVE: begin
				if (in_range) do_close = 1'b1; else st_d = ST_RANGE;
			end
			MODE_POP_AT: begin
				if (in_range) begin
					do_close = 1'b1;
					give_res = 1'b1;
				end else begin
					st_d = ST_RANGE;
				end
			end
			default: begin
				at = cnt_q - CNT_W'(1);
				if (cnt_q == '0) st_d = ST_RANGE;
				else begin
					do_close = 1'b1;
					give_res = 1'b1;
				end
			end
		endcase
	end

	assign sel_val = cell_q[at[IDX_W-1:0]];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			pos_q  <= position;
			val_q  <= DATA_WIDTH'(data_in);
		end
		if (cmd.exec) begin
			res_q <= give_res ? 32'(sel_val) : '0;
			st_q  <= st_d;
			for (int i = 0; i < CAPACITY; i++) begin
				if (do_write && (CNT_W'(i) == at)) begin
					cell_q[i] <= val_q;
				end else if (do_open) begin
					if (CNT_W'(i) == at) cell_q[i] <= val_q;
					else if ((CNT_W'(i) > at) && (i > 0)) cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
				end else if (do_close) begin
					if ((CNT_W'(i) >= at) && (i < CAPACITY - 1)) begin
						cell_q[i] <= cell_q[(i < CAPACITY - 1) ? i + 1 : i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			if (do_open) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_close) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign data_out = res_q;
	assign count    = cnt_q;
	assign status   = st_q;

endmodule
`default_nettype wire

[hdl/indexed_sequence_store.sv]
// top level of the indexed sequence store: controller plus shifting datapath
//
//  channel  | transfer when        | payload
//  ---------+----------------------+------------------------------
//  command  | start && !busy       | mode, position, data_in
//  result   | done (one cycle)     | data_out, count, status
//
// each command passes through an execute step against the cell array and then
// a result step with the result on the ports; a new command is taken in the result
// cycle, but none is taken while a command executes (busy)
// reset clears the length and the controller; cell contents are not reset
// the result is shown for exactly one cycle, the receiver cannot stall it
`default_nettype none
module indexed_sequence_store
	import iss_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [MODE_W-1:0]      mode,
	input  wire logic [POS_W-1:0]       position,
	input  wire logic signed [31:0]     data_in,
	output logic                        done,
	output logic signed [31:0]          data_out,
	output logic [CNT_W-1:0]            count,
	output logic [ST_W-1:0]             status
);

	iss_cmd_t cmd;

	// sequencing: accept, execute, present result
	iss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// cells shift by one place to open or close a slot on insert, append, push, remove and pop
	iss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.mode     (mode),
		.position (position),
		.data_in  (data_in),
		.data_out (data_out),
		.count    (count),
		.status   (status)
	);

	// an accepted command executes in the very next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not execute");

	// execution always ends with a result strobe
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("execute cycle not followed by result");

	// length never exceeds the store size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(CAPACITY))
		else $error("length beyond capacity");

	// a failed operation returns zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (data_out == 32'sd0))
		else $error("nonzero data with error status");

endmodule
`default_nettype wire
